FILE: rtl/bidq_pkg.sv
// bidq_pkg: shared constants and codes for the bounded deque ring
// no dependencies; used by the interfaces, the top level and the bench
package bidq_pkg;

    localparam int DEF_MAX_DEPTH  = 256;
    localparam int DEF_WORD_WIDTH = 32;

    localparam int CAP_W   = 9;
    localparam int CAP_RST = 256;
    localparam int OP_W    = 2;
    localparam int ST_W    = 2;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

endpackage

FILE: rtl/bidq_cmd_if.sv
// bidq_cmd_if: command channel of the deque (opcode and word to store)
// depends on bidq_pkg for field widths
interface bidq_cmd_if #(
    parameter int WORD_WIDTH = bidq_pkg::DEF_WORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic [bidq_pkg::OP_W-1:0]     opcode;
    logic signed [WORD_WIDTH-1:0]  value_in;

    modport source (output valid, output opcode, output value_in, input ready);
    modport sink   (input valid, input opcode, input value_in, output ready);
endinterface

FILE: rtl/bidq_rsp_if.sv
// bidq_rsp_if: response channel of the deque (removed word, empty flag, status)
// depends on bidq_pkg for field widths
interface bidq_rsp_if #(
    parameter int WORD_WIDTH = bidq_pkg::DEF_WORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [WORD_WIDTH-1:0]  value_out;
    logic                          is_empty;
    logic [bidq_pkg::ST_W-1:0]     status;

    modport source (output valid, output value_out, output is_empty, output status,
                    input ready);
    modport sink   (input valid, input value_out, input is_empty, input status,
                    output ready);
endinterface

FILE: rtl/bidq_ram.sv
// bidq_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module bidq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/bounded_int_deque_ring.sv
// bounded_int_deque_ring: ring-buffer deque of signed words, top level
// depends on bidq_pkg, bidq_cmd_if, bidq_rsp_if and bidq_ram
//
//   channel  dir   beat payload                      handshake
//   cmd      in    opcode, value_in                  valid/ready
//   rsp      out   value_out, is_empty, status       valid/ready
//   cfg      in    cfg_wr_data (capacity)            cfg_wr_en, no wait
//
// one command per cycle sustained while rsp is not stalled; a response passes through
// the registered read of the word ram (the read stage) and then the output register
// head and tail pointers live in flops and update in the accept cycle, so
// back-to-back commands never wait on the ram
// reset empties the deque and sets capacity to its reset value; ram contents are not cleared
// a stalled rsp holds the output register, then the read stage, then cmd.ready drops
module bounded_int_deque_ring #(
    parameter int MAX_DEPTH  = bidq_pkg::DEF_MAX_DEPTH,
    parameter int WORD_WIDTH = bidq_pkg::DEF_WORD_WIDTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [bidq_pkg::CAP_W-1:0] cfg_wr_data,
    bidq_cmd_if.sink                   cmd,
    bidq_rsp_if.source                 rsp
);

    localparam int PTR_W    = $clog2(MAX_DEPTH);
    localparam int SIZE_W   = $clog2(MAX_DEPTH + 1);
    localparam int RST_SIZE = (bidq_pkg::CAP_RST > MAX_DEPTH) ? MAX_DEPTH : bidq_pkg::CAP_RST;

    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [SIZE_W-1:0] size_reg, size_next;

    logic                       s1_valid_reg, s1_valid_next;
    logic                       s1_rd_reg, s1_rd_next;
    logic                       s1_empty_reg, s1_empty_next;
    bidq_pkg::status_t          s1_status_reg, s1_status_next;

    logic                       out_valid_reg, out_valid_next;
    logic [WORD_WIDTH-1:0]      out_value_reg, out_value_next;
    logic                       out_empty_reg, out_empty_next;
    bidq_pkg::status_t          out_status_reg, out_status_next;

    logic                  cmd_fire;
    logic                  s1_move;
    logic [SIZE_W-1:0]     tail_inc, head_inc;
    logic [PTR_W-1:0]      tail_wrap, head_wrap, head_dec;
    logic                  ram_wr_en, ram_rd_en;
    logic [PTR_W-1:0]      ram_wr_addr;
    logic [WORD_WIDTH-1:0] ram_rd_data;

    // a result moves from the read stage into the output register
    assign s1_move  = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready = !s1_valid_reg || s1_move;
    assign cmd_fire  = cmd.valid && cmd.ready;

    // wrapping pointer arithmetic against the ring size in use
    always_comb
    begin
        tail_inc  = SIZE_W'(tail_reg) + SIZE_W'(1);
        head_inc  = SIZE_W'(head_reg) + SIZE_W'(1);
        tail_wrap = (tail_inc >= size_reg) ? '0 : PTR_W'(tail_inc);
        head_wrap = (head_inc >= size_reg) ? '0 : PTR_W'(head_inc);
        head_dec  = (head_reg == '0) ? PTR_W'(size_reg - SIZE_W'(1))
                                     : head_reg - PTR_W'(1);
    end

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        size_next      = size_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = tail_reg;
        ram_rd_en      = 1'b0;
        s1_rd_next     = 1'b0;
        s1_status_next = bidq_pkg::ST_OK;

        if (cfg_wr_en)
        begin
            head_next = '0;
            tail_next = '0;
            if (cfg_wr_data < bidq_pkg::CAP_W'(2))
            begin
                size_next = SIZE_W'(2);
            end
            else if (int'(cfg_wr_data) > MAX_DEPTH)
            begin
                size_next = SIZE_W'(MAX_DEPTH);
            end
            else
            begin
                size_next = SIZE_W'(cfg_wr_data);
            end
        end
        else if (cmd_fire)
        begin
            case (bidq_pkg::op_t'(cmd.opcode))
                bidq_pkg::OP_APPEND:
                begin
                    if (tail_wrap == head_reg)
                    begin
                        s1_status_next = bidq_pkg::ST_FULL;
                    end
                    else
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = tail_reg;
                        tail_next   = tail_wrap;
                    end
                end
                bidq_pkg::OP_INSERT:
                begin
                    if (head_dec == tail_reg)
                    begin
                        s1_status_next = bidq_pkg::ST_FULL;
                    end
                    else
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = head_dec;
                        head_next   = head_dec;
                    end
                end
                bidq_pkg::OP_REMOVE:
                begin
                    if (head_reg == tail_reg)
                    begin
                        s1_status_next = bidq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        ram_rd_en  = 1'b1;
                        s1_rd_next = 1'b1;
                        head_next  = head_wrap;
                    end
                end
                default:
                begin
                    head_next = '0;
                    tail_next = '0;
                end
            endcase
        end
        s1_empty_next = (head_next == tail_next);
    end

    bidq_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (MAX_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (cmd.value_in),
        .rd_en   (ram_rd_en),
        .rd_addr (head_reg),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        s1_valid_next   = cmd_fire ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_value_next  = out_value_reg;
        out_empty_next  = out_empty_reg;
        out_status_next = out_status_reg;
        if (s1_move)
        begin
            out_valid_next  = 1'b1;
            out_value_next  = s1_rd_reg ? ram_rd_data : '0;
            out_empty_next  = s1_empty_reg;
            out_status_next = s1_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            size_reg      <= SIZE_W'(RST_SIZE);
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            size_reg      <= size_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            s1_rd_reg     <= s1_rd_next;
            s1_empty_reg  <= s1_empty_next;
            s1_status_reg <= s1_status_next;
        end
        out_value_reg  <= out_value_next;
        out_empty_reg  <= out_empty_next;
        out_status_reg <= out_status_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.value_out = out_value_reg;
    assign rsp.is_empty  = out_empty_reg;
    assign rsp.status    = out_status_reg;

    a_ptr_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (SIZE_W'(head_reg) < size_reg) && (SIZE_W'(tail_reg) < size_reg))
        else $error("deque pointer outside ring");

    a_cfg_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> (head_reg == '0) && (tail_reg == '0))
        else $error("capacity write did not empty the deque");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status != bidq_pkg::ST_OK) |-> (rsp.value_out == '0))
        else $error("error response carries a nonzero word");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !rsp.ready |-> !cmd.ready)
        else $error("command taken while both result stages are full");

    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_wr_en && ram_rd_en))
        else $error("ram read and write in the same cycle");

endmodule

FILE: bench/tb_bounded_int_deque_ring.sv
// tb_bounded_int_deque_ring: self-checking bench for the ring-buffer deque
// depends on bidq_pkg, bidq_cmd_if, bidq_rsp_if and the bounded_int_deque_ring top level
// a directed table is run first, then random phases that each set their own capacity
module tb_bounded_int_deque_ring;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = bidq_pkg::DEF_MAX_DEPTH;
    localparam int WIDTH       = bidq_pkg::DEF_WORD_WIDTH;
    localparam int CAPW        = bidq_pkg::CAP_W;
    localparam int LONG_HOLD   = 150;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_PHASES    = 10;

    typedef struct packed {
        logic [WIDTH-1:0]   word;
        logic               empty;
        bidq_pkg::status_t  st;
    } deque_result_t;

    typedef struct packed {
        bit               is_cfg;
        logic [CAPW-1:0]  cap;
        bidq_pkg::op_t    op;
        logic [WIDTH-1:0] val;
        bit               typed;
        deque_result_t    want;
    } row_t;

    typedef struct packed {
        logic [CAPW-1:0] cap_lo;
        logic [CAPW-1:0] cap_hi;
        int            n_items;
        int            push_pct;
        int            clr_pct;
        int            rx_mode;
        bit            gaps;
        bit            hold;
    } phase_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CAPW-1:0] cfg_wr_data;

    bidq_cmd_if #(.WORD_WIDTH(WIDTH)) cmd_bus ();
    bidq_rsp_if #(.WORD_WIDTH(WIDTH)) rsp_bus ();

    bounded_int_deque_ring #(
        .MAX_DEPTH  (DEPTH),
        .WORD_WIDTH (WIDTH)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd_bus),
        .rsp         (rsp_bus)
    );

    // deque predictor state
    logic [WIDTH-1:0] ring_words [0:DEPTH-1];
    int unsigned      ring_head;
    int unsigned      ring_tail;
    int unsigned      ring_span;

    deque_result_t pending_results [$];
    row_t          script [$];
    phase_t        plan [N_PHASES];

    int fail_cnt   = 0;
    int rx_mode    = 0;
    bit tx_gaps    = 1'b0;
    int burst_left = 0;
    int hold_asks  = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void deque_set_capacity(logic [CAPW-1:0] c);
        if (c < 2)
            ring_span = 2;
        else if (c > DEPTH)
            ring_span = DEPTH;
        else
            ring_span = c;
        ring_head = 0;
        ring_tail = 0;
    endfunction

    function automatic deque_result_t deque_step(bidq_pkg::op_t op, logic [WIDTH-1:0] word);
        deque_result_t r;
        int unsigned   nxt;
        int unsigned   prv;
        r.word = '0;
        r.st   = bidq_pkg::ST_OK;
        case (op)
            bidq_pkg::OP_APPEND:
            begin
                nxt = (ring_tail + 1 >= ring_span) ? 0 : ring_tail + 1;
                if (nxt == ring_head)
                    r.st = bidq_pkg::ST_FULL;
                else
                begin
                    ring_words[ring_tail] = word;
                    ring_tail = nxt;
                end
            end
            bidq_pkg::OP_INSERT:
            begin
                prv = (ring_head == 0) ? ring_span - 1 : ring_head - 1;
                if (prv == ring_tail)
                    r.st = bidq_pkg::ST_FULL;
                else
                begin
                    ring_head = prv;
                    ring_words[prv] = word;
                end
            end
            bidq_pkg::OP_REMOVE:
            begin
                if (ring_head == ring_tail)
                    r.st = bidq_pkg::ST_EMPTY;
                else
                begin
                    r.word = ring_words[ring_head];
                    ring_head = (ring_head + 1 >= ring_span) ? 0 : ring_head + 1;
                end
            end
            default:
            begin
                ring_head = 0;
                ring_tail = 0;
            end
        endcase
        r.empty = (ring_head == ring_tail);
        return r;
    endfunction

    function automatic void flag_mismatch(string what);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("[%0t] MISMATCH: %s", $realtime, what);
    endfunction

    function automatic deque_result_t mk_result(logic [WIDTH-1:0] w, bit e,
                                                bidq_pkg::status_t s);
        deque_result_t r;
        r.word  = w;
        r.empty = e;
        r.st    = s;
        return r;
    endfunction

    function automatic row_t cfg_row(logic [CAPW-1:0] c);
        row_t r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.cap    = c;
        return r;
    endfunction

    // row checked against the predictor
    function automatic row_t op_row(bidq_pkg::op_t op, logic [WIDTH-1:0] v);
        row_t r;
        r     = '0;
        r.op  = op;
        r.val = v;
        return r;
    endfunction

    // row with its result typed in
    function automatic row_t chk_row(bidq_pkg::op_t op, logic [WIDTH-1:0] v,
                                     logic [WIDTH-1:0] ew, bit ee, bidq_pkg::status_t es);
        row_t r;
        r       = op_row(op, v);
        r.typed = 1'b1;
        r.want  = mk_result(ew, ee, es);
        return r;
    endfunction

    task automatic send_item(bidq_pkg::op_t op, logic [WIDTH-1:0] word, bit typed,
                             deque_result_t typed_want);
        deque_result_t predicted;
        int            gap;
        cmd_bus.valid    <= 1'b1;
        cmd_bus.opcode   <= op;
        cmd_bus.value_in <= word;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        predicted = deque_step(op, word);
        pending_results.push_back(typed ? typed_want : predicted);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 15);
            if (tx_gaps)
            begin
                gap = $urandom_range(1, 6);
                cmd_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain_wait();
        cmd_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAPW-1:0] c);
        drain_wait();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= c;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        deque_set_capacity(c);
    endtask

    // receiver: own stall pattern plus long hold-offs on request
    initial
    begin
        int hold_left;
        int hold_seen;
        int rx_tick;
        hold_left = 0;
        hold_seen = 0;
        rx_tick   = 0;
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end
            else if (hold_seen != hold_asks)
            begin
                hold_seen++;
                hold_left = LONG_HOLD - 1;
                rsp_bus.ready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0: rsp_bus.ready <= 1'b1;
                    1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
                    2:
                    begin
                        rx_tick = (rx_tick + 1) % 7;
                        rsp_bus.ready <= (rx_tick >= 3);
                    end
                    default: rsp_bus.ready <= ($urandom_range(0, 2) == 0);
                endcase
            end
        end
    end

    // response checker
    always @(posedge clk)
    begin
        deque_result_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (pending_results.size() == 0)
                flag_mismatch("response beat with nothing expected");
            else
            begin
                want = pending_results.pop_front();
                if (rsp_bus.value_out !== want.word || rsp_bus.is_empty !== want.empty
                    || rsp_bus.status !== want.st)
                    flag_mismatch($sformatf(
                        "value exp %h act %h, empty exp %0d act %0d, status exp %0d act %0d",
                        want.word, rsp_bus.value_out, want.empty, rsp_bus.is_empty,
                        want.st, rsp_bus.status));
            end
        end
    end

    // watchdog
    initial
    begin
        int cyc;
        cyc = 0;
        while (cyc < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cyc++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        bidq_pkg::op_t    op;
        logic [WIDTH-1:0] word;
        logic [WIDTH-1:0] corner [4];
        int               r;
        deque_result_t    none;

        corner = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
        none   = '0;

        rst_n            <= 1'b0;
        cfg_wr_en        <= 1'b0;
        cfg_wr_data      <= '0;
        cmd_bus.valid    <= 1'b0;
        cmd_bus.opcode   <= bidq_pkg::OP_APPEND;
        cmd_bus.value_in <= '0;
        deque_set_capacity(CAPW'(bidq_pkg::CAP_RST));
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset capacity, then smallest ring, then an oversized write
        script.push_back(chk_row(bidq_pkg::OP_REMOVE, 32'h0, 32'h0, 1'b1, bidq_pkg::ST_EMPTY));
        script.push_back(chk_row(bidq_pkg::OP_CLEAR, 32'h1, 32'h0, 1'b1, bidq_pkg::ST_OK));
        script.push_back(chk_row(bidq_pkg::OP_APPEND, 32'h7FFF_FFFF, 32'h0, 1'b0,
                                 bidq_pkg::ST_OK));
        script.push_back(chk_row(bidq_pkg::OP_INSERT, 32'h8000_0000, 32'h0, 1'b0,
                                 bidq_pkg::ST_OK));
        script.push_back(chk_row(bidq_pkg::OP_REMOVE, 32'h0, 32'h8000_0000, 1'b0,
                                 bidq_pkg::ST_OK));
        script.push_back(chk_row(bidq_pkg::OP_REMOVE, 32'h0, 32'h7FFF_FFFF, 1'b1,
                                 bidq_pkg::ST_OK));
        script.push_back(chk_row(bidq_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h0, 1'b0,
                                 bidq_pkg::ST_OK));
        script.push_back(op_row(bidq_pkg::OP_APPEND, 32'h5555_5555));
        script.push_back(op_row(bidq_pkg::OP_APPEND, 32'hAAAA_AAAA));
        script.push_back(op_row(bidq_pkg::OP_REMOVE, 32'h0));
        script.push_back(op_row(bidq_pkg::OP_REMOVE, 32'hFFFF_FFFF));
        script.push_back(op_row(bidq_pkg::OP_REMOVE, 32'h0));
        script.push_back(chk_row(bidq_pkg::OP_REMOVE, 32'h0, 32'h0, 1'b1, bidq_pkg::ST_EMPTY));
        script.push_back(op_row(bidq_pkg::OP_APPEND, 32'h1234_5678));
        script.push_back(chk_row(bidq_pkg::OP_CLEAR, 32'h0, 32'h0, 1'b1, bidq_pkg::ST_OK));
        script.push_back(chk_row(bidq_pkg::OP_REMOVE, 32'h0, 32'h0, 1'b1, bidq_pkg::ST_EMPTY));
        script.push_back(cfg_row(9'd0));
        script.push_back(chk_row(bidq_pkg::OP_APPEND, 32'h1, 32'h0, 1'b0, bidq_pkg::ST_OK));
        script.push_back(chk_row(bidq_pkg::OP_APPEND, 32'h2, 32'h0, 1'b0, bidq_pkg::ST_FULL));
        script.push_back(chk_row(bidq_pkg::OP_INSERT, 32'h3, 32'h0, 1'b0, bidq_pkg::ST_FULL));
        script.push_back(chk_row(bidq_pkg::OP_REMOVE, 32'h0, 32'h1, 1'b1, bidq_pkg::ST_OK));
        script.push_back(chk_row(bidq_pkg::OP_INSERT, 32'h7, 32'h0, 1'b0, bidq_pkg::ST_OK));
        script.push_back(chk_row(bidq_pkg::OP_REMOVE, 32'h0, 32'h7, 1'b1, bidq_pkg::ST_OK));
        script.push_back(cfg_row(9'd511));
        script.push_back(chk_row(bidq_pkg::OP_REMOVE, 32'h0, 32'h0, 1'b1, bidq_pkg::ST_EMPTY));
        script.push_back(op_row(bidq_pkg::OP_INSERT, 32'hDEAD_BEEF));
        script.push_back(op_row(bidq_pkg::OP_CLEAR, 32'h0));

        rx_mode = 1;
        tx_gaps = 1'b1;
        foreach (script[i])
        begin
            if (script[i].is_cfg)
                write_capacity(script[i].cap);
            else
                send_item(script[i].op, script[i].val, script[i].typed, script[i].want);
        end

        // cap range, items, push %, clear %, receiver mode, sender gaps, long hold
        plan = '{
            '{9'd256, 9'd256, 330, 92, 0, 0, 1'b0, 1'b0},
            '{9'd0,   9'd0,    60, 50, 3, 1, 1'b1, 1'b0},
            '{9'd3,   9'd3,    80, 55, 4, 2, 1'b1, 1'b0},
            '{9'd511, 9'd511,  60, 30, 2, 3, 1'b1, 1'b0},
            '{9'd5,   9'd5,   100, 60, 3, 1, 1'b1, 1'b1},
            '{9'd1,   9'd1,    40, 50, 5, 0, 1'b1, 1'b0},
            '{9'd2,   9'd40,  120, 55, 3, 2, 1'b1, 1'b1},
            '{9'd257, 9'd257,  50, 60, 2, 3, 1'b0, 1'b0},
            '{9'd16,  9'd16,  100, 50, 3, 1, 1'b1, 1'b0},
            '{9'd2,   9'd9,   100, 55, 3, 2, 1'b1, 1'b1}
        };

        foreach (plan[p])
        begin
            write_capacity(CAPW'($urandom_range(plan[p].cap_lo, plan[p].cap_hi)));
            rx_mode = plan[p].rx_mode;
            tx_gaps = plan[p].gaps;
            // the receiver holds off while the sender keeps offering, so the block backs up
            if (plan[p].hold)
                hold_asks++;
            repeat (plan[p].n_items)
            begin
                r = $urandom_range(0, 99);
                if (r < plan[p].clr_pct)
                    op = bidq_pkg::OP_CLEAR;
                else if (r < plan[p].clr_pct + plan[p].push_pct)
                    op = $urandom_range(0, 1) ? bidq_pkg::OP_INSERT : bidq_pkg::OP_APPEND;
                else
                    op = bidq_pkg::OP_REMOVE;
                word = ($urandom_range(0, 9) == 0) ? corner[$urandom_range(0, 3)] : $urandom();
                send_item(op, word, 1'b0, none);
            end
        end

        drain_wait();
        if (fail_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
